[sv/urd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_pkg
// Shared widths and the beat carried from cell to cell in the divider chain.
// ----------------------------------------------------------------------------
package urd_pkg;

	localparam int DATA_WIDTH  = 32;
	localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

	// nq holds the dividend bits still to be consumed (upper part) and the
	// quotient bits already produced (lower part), shifting left one per cell.
	typedef struct packed {
		logic [DATA_WIDTH-1:0] rem;
		logic [DATA_WIDTH-1:0] nq;
		logic [DATA_WIDTH-1:0] den;
	} urd_beat_t;

endpackage

[sv/urd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urd_cell
// One restoring-division step: shift in the next dividend bit, trial
// subtract the divisor, keep or restore, and register the result.
// ----------------------------------------------------------------------------
module urd_cell
	import urd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  urd_beat_t in_beat,
	output logic      out_valid,
	input  logic      out_ready,
	output urd_beat_t out_beat
);

	logic              valid_q;
	urd_beat_t         beat_q;
	urd_beat_t         nxt;
	logic [DATA_WIDTH+1:0] trial;
	logic              take;

	always_comb begin
		trial = {1'b0, in_beat.rem, in_beat.nq[DATA_WIDTH-1]} - {2'b00, in_beat.den};
		take  = ~trial[DATA_WIDTH+1];
		nxt.den = in_beat.den;
		nxt.rem = take ? trial[DATA_WIDTH-1:0]
		               : {in_beat.rem[DATA_WIDTH-2:0], in_beat.nq[DATA_WIDTH-1]};
		nxt.nq  = {in_beat.nq[DATA_WIDTH-2:0], take};
	end

	assign in_ready  = ~valid_q | out_ready;
	assign out_valid = valid_q;
	assign out_beat  = beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// advance payload only on an accepted beat
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_q <= nxt;
		end
	end

endmodule

[sv/unsigned_restoring_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_restoring_divider
// Pipelined unsigned restoring divider built from a chain of one-bit cells.
// ----------------------------------------------------------------------------
// Takes one dividend/divisor pair per beat and returns the unsigned quotient,
// truncated toward zero; a zero divisor returns all ones and raises no flag.
// The chain has DATA_WIDTH cells (32), each resolving one quotient bit and
// registering its result, and a new pair is accepted every cycle while the
// output is not stalled or the chain still has a gap. Each cell has
// its own valid bit and ready, so gaps in the chain close up while the
// output is stalled, and the last cell serves as the output register.
module unsigned_restoring_divider
	import urd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // dividend, divisor
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // quotient
);

	logic      valid [0:DATA_WIDTH];
	logic      ready [0:DATA_WIDTH];
	urd_beat_t beat  [0:DATA_WIDTH];

	assign valid[0]      = s_axis_tvalid;
	assign s_axis_tready = ready[0];
	assign beat[0].rem   = '0;
	assign beat[0].nq    = s_axis_tdata[DATA_WIDTH-1:0];
	assign beat[0].den   = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		urd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid[i]),
			.in_ready (ready[i]),
			.in_beat  (beat[i]),
			.out_valid(valid[i+1]),
			.out_ready(ready[i+1]),
			.out_beat (beat[i+1])
		);
	end

	assign ready[DATA_WIDTH] = m_axis_tready;
	assign m_axis_tvalid     = valid[DATA_WIDTH];
	assign m_axis_tdata      = OUT_TDATA_W'(beat[DATA_WIDTH].nq);

	logic all_full;

	always_comb begin
		all_full = 1'b1;
		for (int k = 1; k <= DATA_WIDTH; k++) begin
			all_full = all_full & valid[k];
		end
	end

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!all_full || m_axis_tready))
		else $error("input ready disagrees with chain occupancy");

	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (beat[DATA_WIDTH].den == '0) |->
		(beat[DATA_WIDTH].nq == {DATA_WIDTH{1'b1}}))
		else $error("zero divisor did not give all-ones quotient");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (beat[DATA_WIDTH].den != '0) |->
		(beat[DATA_WIDTH].rem < beat[DATA_WIDTH].den))
		else $error("final remainder not below divisor");

endmodule
